// ----- rtl/piq_pkg.sv -----
// Shared types, sizes and codes for the priority insert round-robin queue.
package piq_pkg;

	localparam int DEPTH      = 16;
	localparam int PRIO_WIDTH = 8;
	localparam int ID_W       = 8;
	localparam int PTR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int SUM_W      = PTR_W + 1;

	typedef logic [PTR_W-1:0]      ptr_t;
	typedef logic [CNT_W-1:0]      cnt_t;
	typedef logic [ID_W-1:0]       tid_t;
	typedef logic [PRIO_WIDTH-1:0] prio_t;

	typedef enum logic {
		REQ_INSERT = 1'b0,
		REQ_NEXT   = 1'b1
	} req_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_LAST,
		S_NEXT,
		S_RESP
	} state_t;

	typedef struct packed {
		tid_t  id;
		prio_t prio;
	} entry_t;

	typedef struct packed {
		logic   en;
		ptr_t   addr;
		entry_t data;
	} wr_t;

	typedef struct packed {
		tid_t    chosen_id;
		status_t status;
	} res_t;

	// Physical slot of a logical queue position, wrapping around the ring.
	function automatic ptr_t slot_addr(ptr_t base, cnt_t off);
		logic [SUM_W-1:0] sum;
		sum = {1'b0, base} + SUM_W'(off);
		if (sum >= SUM_W'(DEPTH)) begin
			sum = sum - SUM_W'(DEPTH);
		end
		return sum[PTR_W-1:0];
	endfunction

endpackage

// ----- rtl/piq_store.sv -----
// Entry storage ring: one write port, one registered read port.
module piq_store
	import piq_pkg::*;
(
	input  logic   clk,
	input  ptr_t   raddr,
	output entry_t rdata,
	input  wr_t    wr
);

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/piq_seq.sv -----
// Sequencer with the shared priority comparator that walks the entry ring.
module piq_seq
	import piq_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  logic   req_type,
	input  tid_t   thread_id,
	input  logic [7:0] priority_req,
	output logic   res_valid,
	input  logic   res_ready,
	output res_t   res,
	output ptr_t   raddr,
	input  entry_t rdata,
	output wr_t    wr
);

	state_t state_q, state_d;
	ptr_t   head_q;
	cnt_t   cnt_q;
	cnt_t   k_q;
	logic   ins_q;
	entry_t new_q;
	entry_t carry_q;
	res_t   res_q;

	logic accept;
	logic is_next;
	logic cmp_less;
	logic last_k;

	assign accept   = in_valid && in_ready;
	assign is_next  = (req_t'(req_type) == REQ_NEXT);
	assign cmp_less = (new_q.prio < rdata.prio);
	assign last_k   = (k_q == (cnt_q - CNT_W'(1)));

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (is_next) begin
						state_d = (cnt_q == '0) ? S_RESP : S_NEXT;
					end else if (cnt_q == CNT_W'(DEPTH)) begin
						state_d = S_RESP;
					end else begin
						state_d = (cnt_q == '0) ? S_LAST : S_SCAN;
					end
				end
			end
			S_SCAN: begin
				if (last_k) begin
					state_d = S_LAST;
				end
			end
			S_LAST:  state_d = S_RESP;
			S_NEXT:  state_d = S_RESP;
			S_RESP: begin
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		res_valid = 1'b0;
		raddr     = head_q;
		wr        = '0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
			end
			S_SCAN: begin
				raddr   = slot_addr(head_q, k_q + CNT_W'(1));
				wr.en   = ins_q || cmp_less;
				wr.addr = slot_addr(head_q, k_q);
				wr.data = ins_q ? carry_q : new_q;
			end
			S_LAST: begin
				wr.en   = 1'b1;
				wr.addr = slot_addr(head_q, k_q);
				wr.data = ins_q ? carry_q : new_q;
			end
			S_NEXT: begin
				wr.en   = 1'b1;
				wr.addr = slot_addr(head_q, cnt_q);
				wr.data = rdata;
			end
			S_RESP: begin
				res_valid = 1'b1;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	assign res = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			cnt_q   <= '0;
			k_q     <= '0;
			ins_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						k_q   <= '0;
						ins_q <= 1'b0;
					end
				end
				S_SCAN: begin
					k_q <= k_q + CNT_W'(1);
					if (cmp_less) begin
						ins_q <= 1'b1;
					end
				end
				S_LAST: begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
				S_NEXT: begin
					head_q <= slot_addr(head_q, CNT_W'(1));
				end
				default: begin
					k_q <= k_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && accept) begin
			new_q.id            <= thread_id;
			new_q.prio          <= priority_req[PRIO_WIDTH-1:0];
			res_q.chosen_id     <= '0;
			if (is_next && cnt_q == '0) begin
				res_q.status <= ST_EMPTY;
			end else if (!is_next && cnt_q == CNT_W'(DEPTH)) begin
				res_q.status <= ST_FULL;
			end else begin
				res_q.status <= ST_DONE;
			end
		end
		if (state_q == S_SCAN && (ins_q || cmp_less)) begin
			carry_q <= rdata;
		end
		if (state_q == S_NEXT) begin
			res_q.chosen_id <= rdata.id;
		end
	end

endmodule

// ----- rtl/priority_insert_round_robin_queue.sv -----
// Top level of the priority-ordered ready queue with round-robin rotation.
//
// Input channel (in_valid/in_ready) takes one request word: req_type selects
// insert (place thread_id before the first entry of strictly greater
// priority_req, else at the tail) or next (take the head, rotate it to the
// tail). Output channel (out_valid/out_ready) returns one word per request:
// chosen_id (head identifier on a good next, else zero) and status (done,
// insert dropped on full queue, next on empty queue).
// Entries sit in a ring of DEPTH slots; one comparator walks it from the head,
// one slot a cycle, writing the new entry and carrying each displaced entry
// one slot toward the tail in the same pass.
// An insert into n entries compares each of them in S_SCAN, then writes the
// last slot in S_LAST; a next reads and rotates the head in S_NEXT; a full or
// empty case goes straight to S_RESP. A new word is taken in the cycle after
// the result is loaded, so the block takes no word while one is in work.
// The result register lets the next word be taken while out_ready is low;
// a later result then holds in the sequencer until the register drains.
// Reset empties the queue at once; slot contents are not cleared.
module priority_insert_round_robin_queue
	import piq_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       req_type,
	input  logic [7:0] thread_id,
	input  logic [7:0] priority_req,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] chosen_id,
	output logic [1:0] status
);

	ptr_t   raddr;
	entry_t rdata;
	wr_t    wr;
	logic   res_valid;
	logic   res_ready;
	res_t   res;

	logic   out_valid_q;
	res_t   out_q;

	// Storage ring.
	piq_store u_store (
		.clk   (clk),
		.raddr (raddr),
		.rdata (rdata),
		.wr    (wr)
	);

	// Scan sequencer and comparator.
	piq_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.req_type     (req_type),
		.thread_id    (thread_id),
		.priority_req (priority_req),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.res          (res),
		.raddr        (raddr),
		.rdata        (rdata),
		.wr           (wr)
	);

	// Result register: load when empty or draining this cycle.
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign chosen_id = out_q.chosen_id;
	assign status    = out_q.status;

	// Accepting a word always takes the sequencer out of idle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("sequencer stayed idle after accepting a word");

	// A finished result is only offered while no word can be taken.
	a_res_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !in_ready)
		else $error("result offered while input is open");

	// Only a good next carries an identifier.
	a_id_zero_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_FULL || status == ST_EMPTY) |-> chosen_id == '0)
		else $error("nonzero identifier on a failed request");

endmodule
